// File: src/polyab_pkg.sv
// polyab_pkg: widths, limits and payload types shared by the polygon area and box block
// depends on nothing; used by every module under src
package polyab_pkg;

   // coordinate and arithmetic widths
   localparam int COORD_W   = 24;
   localparam int BOX_MAX_W = COORD_W - 1;
   localparam int PROD_W    = 2 * COORD_W;
   localparam int PSUM_W    = PROD_W + 2;
   localparam int CROSS_W   = 58;
   localparam int AREA_W    = 62;

   // saturation limits
   localparam logic signed [CROSS_W-1:0] CROSS_MAX = {1'b0, {(CROSS_W-1){1'b1}}};
   localparam logic signed [CROSS_W-1:0] CROSS_MIN = {1'b1, {(CROSS_W-1){1'b0}}};
   localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};
   localparam logic signed [COORD_W-1:0] COORD_POS_MAX = {1'b0, {(COORD_W-1){1'b1}}};

   // one vertex transfer
   typedef struct packed {
      logic signed [COORD_W-1:0] x_coord;
      logic signed [COORD_W-1:0] y_coord;
      logic                      ends_polygon;
      logic                      ends_instance;
      logic                      no_vertex;
   } polyab_req_type;

   // one instance result
   typedef struct packed {
      logic [AREA_W-1:0]         instance_area;
      logic signed [COORD_W-1:0] box_min_x;
      logic signed [COORD_W-1:0] box_min_y;
      logic [BOX_MAX_W-1:0]      box_max_x;
      logic [BOX_MAX_W-1:0]      box_max_y;
      logic                      area_saturated;
   } polyab_rsp_type;

   // classification of a vertex as made by the front
   typedef struct packed {
      logic no_vertex;
      logic restart;
      logic closes;
      logic ends_inst;
   } polyab_flags_type;

   // queue entry: prefix sums of the cross terms and the saturated outcomes
   typedef struct packed {
      polyab_flags_type          flags;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [PSUM_W-1:0]  p_end;
      logic signed [PSUM_W-1:0]  p_max;
      logic signed [PSUM_W-1:0]  p_min;
      logic signed [CROSS_W-1:0] hi_res;
      logic signed [CROSS_W-1:0] lo_res;
   } polyab_job_type;

endpackage

// File: src/polyab_front.sv
// polyab_front: vertex intake, polygon tracking, cross products and prefix sums
// depends on polyab_pkg
module polyab_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  polyab_pkg::polyab_req_type req_data,
   output logic                       job_valid,
   input  logic                       job_ready,
   output polyab_pkg::polyab_job_type job_data
);

   localparam int CW = polyab_pkg::COORD_W;
   localparam int PW = polyab_pkg::PROD_W;
   localparam int SW = polyab_pkg::PSUM_W;
   localparam int XW = polyab_pkg::CROSS_W + 1;
   localparam logic signed [XW-1:0] CMAX_E = XW'(polyab_pkg::CROSS_MAX);
   localparam logic signed [XW-1:0] CMIN_E = XW'(polyab_pkg::CROSS_MIN);

   logic adv1, adv2, adv3, adv4, req_xfer;

   // polygon tracking state
   logic start_ff, start_in;
   logic signed [CW-1:0] first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic signed [CW-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [CW-1:0] x_now, y_now, fsel_x, fsel_y;

   // stage 1: raw products
   logic f1_v_ff;
   polyab_pkg::polyab_flags_type f1_flags_ff, f1_flags_in;
   logic signed [CW-1:0] f1_x_ff, f1_y_ff;
   logic signed [PW-1:0] f1_pa_ff, f1_pa_in, f1_pb_ff, f1_pb_in;
   logic signed [PW-1:0] f1_pc_ff, f1_pc_in, f1_pd_ff, f1_pd_in;

   // stage 2: prefix sums
   logic f2_v_ff;
   polyab_pkg::polyab_flags_type f2_flags_ff;
   logic signed [CW-1:0] f2_x_ff, f2_y_ff;
   logic signed [SW-1:0] ta, tb, tc, td;
   logic signed [SW-1:0] f2_p1_ff, f2_p1_in, f2_p2_ff, f2_p2_in;
   logic signed [SW-1:0] f2_p3_ff, f2_p3_in, f2_p4_ff, f2_p4_in;

   // stage 3: extremes of the prefix sums
   logic f3_v_ff;
   polyab_pkg::polyab_flags_type f3_flags_ff;
   logic signed [CW-1:0] f3_x_ff, f3_y_ff;
   logic signed [SW-1:0] mx12, mx34, mn12, mn34;
   logic signed [SW-1:0] f3_pend_ff, f3_pmax_ff, f3_pmax_in, f3_pmin_ff, f3_pmin_in;

   // stage 4: saturated outcomes
   logic f4_v_ff;
   polyab_pkg::polyab_job_type job_ff, job_in;

   // stall chain, last stage first
   assign adv4      = !f4_v_ff || job_ready;
   assign adv3      = !f3_v_ff || adv4;
   assign adv2      = !f2_v_ff || adv3;
   assign adv1      = !f1_v_ff || adv2;
   assign req_ready = adv1;
   assign req_xfer  = req_valid && req_ready;
   assign job_valid = f4_v_ff;
   assign job_data  = job_ff;

   assign x_now  = req_data.x_coord;
   assign y_now  = req_data.y_coord;
   assign fsel_x = start_ff ? x_now : first_x_ff;
   assign fsel_y = start_ff ? y_now : first_y_ff;

   // next polygon state on a vertex transfer
   always_comb begin
      start_in   = start_ff;
      first_x_in = first_x_ff;
      first_y_in = first_y_ff;
      prev_x_in  = prev_x_ff;
      prev_y_in  = prev_y_ff;
      if (req_xfer) begin
         if (req_data.no_vertex) begin
            start_in = 1'b1;
         end else begin
            prev_x_in = x_now;
            prev_y_in = y_now;
            if (start_ff) begin
               first_x_in = x_now;
               first_y_in = y_now;
            end
            start_in = req_data.ends_polygon;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff   <= 1'b1;
         first_x_ff <= '0;
         first_y_ff <= '0;
         prev_x_ff  <= '0;
         prev_y_ff  <= '0;
      end else begin
         start_ff   <= start_in;
         first_x_ff <= first_x_in;
         first_y_ff <= first_y_in;
         prev_x_ff  <= prev_x_in;
         prev_y_ff  <= prev_y_in;
      end
   end

   // stage 1: classify and multiply
   always_comb begin
      f1_flags_in.no_vertex = req_data.no_vertex;
      f1_flags_in.restart   = start_ff;
      f1_flags_in.closes    = req_data.ends_polygon && !req_data.no_vertex;
      f1_flags_in.ends_inst = req_data.ends_instance;
      f1_pa_in = x_now * prev_y_ff;
      f1_pb_in = y_now * prev_x_ff;
      f1_pc_in = fsel_x * y_now;
      f1_pd_in = fsel_y * x_now;
   end

   // stage 2: mask unused terms and form the four running sums
   always_comb begin
      ta = '0;
      tb = '0;
      tc = '0;
      td = '0;
      if (!f1_flags_ff.restart && !f1_flags_ff.no_vertex) begin
         ta = SW'(f1_pa_ff);
         tb = SW'(f1_pb_ff);
      end
      if (f1_flags_ff.closes) begin
         tc = SW'(f1_pc_ff);
         td = SW'(f1_pd_ff);
      end
      f2_p1_in = ta;
      f2_p2_in = ta - tb;
      f2_p3_in = ta - tb + tc;
      f2_p4_in = ta - tb + tc - td;
   end

   // stage 3: largest and smallest running sum
   always_comb begin
      mx12 = (f2_p1_ff > f2_p2_ff) ? f2_p1_ff : f2_p2_ff;
      mx34 = (f2_p3_ff > f2_p4_ff) ? f2_p3_ff : f2_p4_ff;
      mn12 = (f2_p1_ff < f2_p2_ff) ? f2_p1_ff : f2_p2_ff;
      mn34 = (f2_p3_ff < f2_p4_ff) ? f2_p3_ff : f2_p4_ff;
      f3_pmax_in = (mx12 > mx34) ? mx12 : mx34;
      f3_pmin_in = (mn12 < mn34) ? mn12 : mn34;
   end

   // stage 4: value left after a clamp at either limit
   always_comb begin
      logic signed [XW-1:0] hi_e;
      logic signed [XW-1:0] lo_e;
      hi_e = CMAX_E - XW'(f3_pmax_ff) + XW'(f3_pend_ff);
      lo_e = CMIN_E - XW'(f3_pmin_ff) + XW'(f3_pend_ff);
      job_in.flags  = f3_flags_ff;
      job_in.x      = f3_x_ff;
      job_in.y      = f3_y_ff;
      job_in.p_end  = f3_pend_ff;
      job_in.p_max  = f3_pmax_ff;
      job_in.p_min  = f3_pmin_ff;
      job_in.hi_res = hi_e[XW-2:0];
      job_in.lo_res = lo_e[XW-2:0];
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
         f2_v_ff <= 1'b0;
         f3_v_ff <= 1'b0;
         f4_v_ff <= 1'b0;
      end else begin
         if (adv1) f1_v_ff <= req_valid;
         if (adv2) f2_v_ff <= f1_v_ff;
         if (adv3) f3_v_ff <= f2_v_ff;
         if (adv4) f4_v_ff <= f3_v_ff;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (adv1) begin
         f1_flags_ff <= f1_flags_in;
         f1_x_ff     <= x_now;
         f1_y_ff     <= y_now;
         f1_pa_ff    <= f1_pa_in;
         f1_pb_ff    <= f1_pb_in;
         f1_pc_ff    <= f1_pc_in;
         f1_pd_ff    <= f1_pd_in;
      end
      if (adv2) begin
         f2_flags_ff <= f1_flags_ff;
         f2_x_ff     <= f1_x_ff;
         f2_y_ff     <= f1_y_ff;
         f2_p1_ff    <= f2_p1_in;
         f2_p2_ff    <= f2_p2_in;
         f2_p3_ff    <= f2_p3_in;
         f2_p4_ff    <= f2_p4_in;
      end
      if (adv3) begin
         f3_flags_ff <= f2_flags_ff;
         f3_x_ff     <= f2_x_ff;
         f3_y_ff     <= f2_y_ff;
         f3_pend_ff  <= f2_p4_ff;
         f3_pmax_ff  <= f3_pmax_in;
         f3_pmin_ff  <= f3_pmin_in;
      end
      if (adv4) begin
         job_ff <= job_in;
      end
   end

endmodule

// File: src/polyab_queue.sv
// polyab_queue: short first-in first-out buffer between front and back
// depends on polyab_pkg
module polyab_queue #(
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  polyab_pkg::polyab_job_type in_data,
   output logic                       out_valid,
   input  logic                       out_ready,
   output polyab_pkg::polyab_job_type out_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   polyab_pkg::polyab_job_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic push, pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = slot_ff[rd_ptr_ff];

   // pointer wrap and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// File: src/polyab_back.sv
// polyab_back: cross sum accumulation, area and bounding box per instance, result register
// depends on polyab_pkg
module polyab_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       job_valid,
   output logic                       job_ready,
   input  polyab_pkg::polyab_job_type job_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output polyab_pkg::polyab_rsp_type rsp_data
);

   localparam int CW = polyab_pkg::COORD_W;
   localparam int MW = polyab_pkg::BOX_MAX_W;
   localparam int XW = polyab_pkg::CROSS_W + 1;
   localparam int KW = polyab_pkg::CROSS_W;
   localparam int AW = polyab_pkg::AREA_W;
   localparam logic signed [XW-1:0] CMAX_E = XW'(polyab_pkg::CROSS_MAX);
   localparam logic signed [XW-1:0] CMIN_E = XW'(polyab_pkg::CROSS_MIN);

   typedef struct packed {
      logic                 vertex;
      logic                 closes;
      logic                 emit;
      logic                 sat;
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
   } polyab_tag_type;

   logic en, pop;

   // cross sum stage
   logic signed [KW-1:0] cross_ff, cross_in;
   logic signed [XW-1:0] c_ext, s_hi, s_lo, s_end;
   logic hi, lo;
   logic signed [KW-1:0] res;
   logic b1_v_ff;
   polyab_tag_type b1_tag_ff, b1_tag_in;
   logic signed [KW-1:0] b1_val_ff;

   // magnitude stage
   logic b2_v_ff;
   polyab_tag_type b2_tag_ff;
   logic [KW-1:0] b2_mag_ff, b2_mag_in;

   // instance state
   logic [AW-1:0] area_ff, area_in, area_new;
   logic sat_ff, sat_in, sat_new, area_sat;
   logic [AW:0] area_sum;
   logic signed [CW-1:0] min_x_ff, min_x_in, min_x_new, min_y_ff, min_y_in, min_y_new;
   logic [MW-1:0] max_x_ff, max_x_in, max_x_new, max_y_ff, max_y_in, max_y_new;
   logic signed [CW-1:0] max_x_e, max_y_e;

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   polyab_pkg::polyab_rsp_type rsp_data_ff, rsp_data_in;

   // the whole back halts only while a result waits
   assign en        = !rsp_valid_ff || rsp_ready;
   assign job_ready = en;
   assign pop       = job_valid && en;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // cross sum update: the upper clamp takes priority over the lower one
   always_comb begin
      if (job_data.flags.restart) begin
         c_ext = '0;
      end else begin
         c_ext = XW'(cross_ff);
      end
      s_hi  = c_ext + XW'(job_data.p_max);
      s_lo  = c_ext + XW'(job_data.p_min);
      s_end = c_ext + XW'(job_data.p_end);
      hi    = (s_hi > CMAX_E);
      lo    = (s_lo < CMIN_E);
      if (hi) begin
         res = job_data.hi_res;
      end else if (lo) begin
         res = job_data.lo_res;
      end else begin
         res = s_end[KW-1:0];
      end
      cross_in = cross_ff;
      if (pop && !job_data.flags.no_vertex) begin
         cross_in = res;
      end
      b1_tag_in.vertex = !job_data.flags.no_vertex;
      b1_tag_in.closes = job_data.flags.closes;
      b1_tag_in.emit   = job_data.flags.no_vertex
                         || (job_data.flags.closes && job_data.flags.ends_inst);
      b1_tag_in.sat    = !job_data.flags.no_vertex && (hi || lo);
      b1_tag_in.x      = job_data.x;
      b1_tag_in.y      = job_data.y;
   end

   // absolute value of a closed polygon's sum
   assign b2_mag_in = b1_val_ff[KW-1] ? (~b1_val_ff + 1'b1) : b1_val_ff;

   // area accumulation and box tracking
   always_comb begin
      area_sum = {1'b0, area_ff} + (AW + 1)'(b2_mag_ff);
      area_new = area_ff;
      area_sat = 1'b0;
      if (b2_tag_ff.closes) begin
         if (area_sum >= {1'b0, polyab_pkg::AREA_MAX}) begin
            area_new = polyab_pkg::AREA_MAX;
            area_sat = 1'b1;
         end else begin
            area_new = area_sum[AW-1:0];
         end
      end
      sat_new = sat_ff || b2_tag_ff.sat || area_sat;
      max_x_e = CW'({1'b0, max_x_ff});
      max_y_e = CW'({1'b0, max_y_ff});
      min_x_new = min_x_ff;
      min_y_new = min_y_ff;
      max_x_new = max_x_ff;
      max_y_new = max_y_ff;
      if (b2_tag_ff.vertex) begin
         if (b2_tag_ff.x < min_x_ff) min_x_new = b2_tag_ff.x;
         if (b2_tag_ff.y < min_y_ff) min_y_new = b2_tag_ff.y;
         if (b2_tag_ff.x > max_x_e)  max_x_new = b2_tag_ff.x[MW-1:0];
         if (b2_tag_ff.y > max_y_e)  max_y_new = b2_tag_ff.y[MW-1:0];
      end

      rsp_data_in.instance_area  = area_new;
      rsp_data_in.box_min_x      = min_x_new;
      rsp_data_in.box_min_y      = min_y_new;
      rsp_data_in.box_max_x      = max_x_new;
      rsp_data_in.box_max_y      = max_y_new;
      rsp_data_in.area_saturated = sat_new;

      area_in  = area_ff;
      sat_in   = sat_ff;
      min_x_in = min_x_ff;
      min_y_in = min_y_ff;
      max_x_in = max_x_ff;
      max_y_in = max_y_ff;
      if (en && b2_v_ff) begin
         if (b2_tag_ff.emit) begin
            area_in  = '0;
            sat_in   = 1'b0;
            min_x_in = polyab_pkg::COORD_POS_MAX;
            min_y_in = polyab_pkg::COORD_POS_MAX;
            max_x_in = '0;
            max_y_in = '0;
         end else begin
            area_in  = area_new;
            sat_in   = sat_new;
            min_x_in = min_x_new;
            min_y_in = min_y_new;
            max_x_in = max_x_new;
            max_y_in = max_y_new;
         end
      end
      rsp_valid_in = rsp_valid_ff;
      if (en) begin
         rsp_valid_in = b2_v_ff && b2_tag_ff.emit;
      end
   end

   // control and accumulator state
   always_ff @(posedge clock) begin
      if (reset) begin
         cross_ff     <= '0;
         b1_v_ff      <= 1'b0;
         b2_v_ff      <= 1'b0;
         area_ff      <= '0;
         sat_ff       <= 1'b0;
         min_x_ff     <= polyab_pkg::COORD_POS_MAX;
         min_y_ff     <= polyab_pkg::COORD_POS_MAX;
         max_x_ff     <= '0;
         max_y_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cross_ff     <= cross_in;
         area_ff      <= area_in;
         sat_ff       <= sat_in;
         min_x_ff     <= min_x_in;
         min_y_ff     <= min_y_in;
         max_x_ff     <= max_x_in;
         max_y_ff     <= max_y_in;
         rsp_valid_ff <= rsp_valid_in;
         if (en) begin
            b1_v_ff <= pop;
            b2_v_ff <= b1_v_ff;
         end
      end
   end

   // stage payloads and result data
   always_ff @(posedge clock) begin
      if (en) begin
         b1_tag_ff   <= b1_tag_in;
         b1_val_ff   <= res;
         b2_tag_ff   <= b1_tag_ff;
         b2_mag_ff   <= b2_mag_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// File: src/polygon_instance_area_and_bbox.sv
// polygon_instance_area_and_bbox: top level of the polygon area and bounding box block
// depends on polyab_pkg, polyab_front, polyab_queue, polyab_back

// Streams polygon vertices (signed Q15.8) one per transfer and returns one result per
// instance: the summed shoelace area with 17 fraction bits, saturated at its maximum with
// area_saturated set, and the bounding box, whose minimum starts at the largest positive
// code and whose maximum starts at zero. A vertex is taken every cycle while req_ready
// is high; the front is a four-stage pipeline (products, running sums, extremes, clamp
// outcomes) and the back a three-stage pipeline whose cross sum loop through cross_ff sets
// that rate. rsp_valid rises once the vertex closing its instance has passed the front
// stages, the queue and the back stages. The back halts only while a result waits untaken;
// the front keeps accepting until the queue between them holds QUEUE_DEPTH entries and the
// four front stages are full behind it. No clearing pass is needed after reset.
module polygon_instance_area_and_bbox #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  polyab_pkg::polyab_req_type req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output polyab_pkg::polyab_rsp_type rsp_data
);

   logic fq_valid, fq_ready, qb_valid, qb_ready;
   polyab_pkg::polyab_job_type fq_data, qb_data;

   // intake and arithmetic preparation
   polyab_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .job_valid (fq_valid),
      .job_ready (fq_ready),
      .job_data  (fq_data)
   );

   // decoupling buffer
   polyab_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_data)
   );

   // accumulation and result
   polyab_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (qb_valid),
      .job_ready (qb_ready),
      .job_data  (qb_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // an area at its limit always carries the saturation flag
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.instance_area == polyab_pkg::AREA_MAX)
      |-> rsp_data.area_saturated)
      else $error("area at limit without saturation flag");

   // once a vertex is seen the box is ordered in x
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.box_min_x == polyab_pkg::COORD_POS_MAX
                     || rsp_data.box_min_x <= $signed({1'b0, rsp_data.box_max_x})))
      else $error("box minimum above maximum");

   // a non-zero area needs at least one vertex in the box
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.instance_area != '0)
      |-> !(rsp_data.box_min_x == polyab_pkg::COORD_POS_MAX && rsp_data.box_max_x == '0))
      else $error("area reported for an instance without vertices");

   // the queue refuses entries only while it holds some
   assert property (@(posedge clock) disable iff (reset)
      (fq_valid && !fq_ready) |-> qb_valid)
      else $error("queue refuses entries while empty");

endmodule
